// ----- rtl/fjr_pkg.sv -----
// ----------------------------------------------------------------------------
// fjr_pkg
// Shared types, codes and reset values for the feeder jam recovery block.
// ----------------------------------------------------------------------------
package fjr_pkg;

   localparam int TORQUE_W  = 16;
   localparam int ANGLE_W   = 32;
   localparam int MS_W      = 32;
   localparam int STATE_W   = 3;
   localparam int TICK_W    = 8;
   localparam int THR_W     = 15;
   localparam int HOLD_W    = 16;
   localparam int BACKOFF_W = 19;
   localparam int MODE_W    = 2;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam logic [STATE_W-1:0] ST_NORMAL  = 3'd0;
   localparam logic [STATE_W-1:0] ST_SUSPECT = 3'd1;
   localparam logic [STATE_W-1:0] ST_REACT   = 3'd2;
   localparam logic [STATE_W-1:0] ST_BACKOFF = 3'd3;
   localparam logic [STATE_W-1:0] ST_STALLED = 3'd4;

   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ANGLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd2;

   localparam logic [2:0] REG_TORQUE_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_SUSPECT_TICKS    = 3'd1;
   localparam logic [2:0] REG_RECOVER_TICKS    = 3'd2;
   localparam logic [2:0] REG_STALL_TICKS      = 3'd3;
   localparam logic [2:0] REG_HOLD_MS          = 3'd4;
   localparam logic [2:0] REG_BACKOFF_ANGLE    = 3'd5;

   localparam logic [THR_W-1:0]     RST_TORQUE_THRESHOLD = 15'd8000;
   localparam logic [TICK_W-1:0]    RST_SUSPECT_TICKS    = 8'd100;
   localparam logic [TICK_W-1:0]    RST_RECOVER_TICKS    = 8'd200;
   localparam logic [TICK_W-1:0]    RST_STALL_TICKS      = 8'd200;
   localparam logic [HOLD_W-1:0]    RST_HOLD_MS          = 16'd2000;
   localparam logic [BACKOFF_W-1:0] RST_BACKOFF_ANGLE    = 19'd17157;

   typedef struct packed {
      logic [THR_W-1:0]     torque_threshold;
      logic [TICK_W-1:0]    suspect_ticks;
      logic [TICK_W-1:0]    recover_ticks;
      logic [TICK_W-1:0]    stall_ticks;
      logic [HOLD_W-1:0]    hold_ms;
      logic [BACKOFF_W-1:0] backoff_angle;
   } cfg_type;

   typedef struct packed {
      logic [STATE_W-1:0] jam_state;
      logic [TICK_W-1:0]  ticks_in_state;
      logic [TICK_W-1:0]  low_torque_run;
      logic [TICK_W-1:0]  high_torque_run;
      logic [MS_W-1:0]    stall_start_ms;
   } ctx_type;

   typedef struct packed {
      logic [STATE_W-1:0]       jam_state;
      logic                     run_normal_drive;
      logic [MODE_W-1:0]        mode_command;
      logic                     target_command;
      logic                     angle_update;
      logic signed [ANGLE_W-1:0] target_angle;
      logic                     clear_drive;
   } rsp_type;

endpackage

// ----- rtl/fjr_if.sv -----
// ----------------------------------------------------------------------------
// fjr_req_if / fjr_rsp_if
// Valid/ready channels carrying one control tick request and its result.
// ----------------------------------------------------------------------------
interface fjr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fjr_pkg::TORQUE_W-1:0]   torque;
   logic signed [fjr_pkg::ANGLE_W-1:0]    angle;
   logic [fjr_pkg::MS_W-1:0]              now_ms;

   modport source (output valid, output torque, output angle, output now_ms, input ready);
   modport sink   (input valid, input torque, input angle, input now_ms, output ready);
endinterface

interface fjr_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [fjr_pkg::STATE_W-1:0]           jam_state;
   logic                                  run_normal_drive;
   logic [fjr_pkg::MODE_W-1:0]            mode_command;
   logic                                  target_command;
   logic                                  angle_update;
   logic signed [fjr_pkg::ANGLE_W-1:0]    target_angle;
   logic                                  clear_drive;

   modport source (output valid, output jam_state, output run_normal_drive,
                   output mode_command, output target_command, output angle_update,
                   output target_angle, output clear_drive, input ready);
   modport sink   (input valid, input jam_state, input run_normal_drive,
                   input mode_command, input target_command, input angle_update,
                   input target_angle, input clear_drive, output ready);
endinterface

// ----- rtl/feeder_jam_recovery_fsm.sv -----
// ----------------------------------------------------------------------------
// feeder_jam_recovery_fsm
// Five-state feeder jam handler: one request per control tick, one result.
//
//   channel    direction  handshake      contents
//   req_chan   in         valid/ready    torque, angle, now_ms
//   rsp_chan   out        valid/ready    jam_state, drive and angle commands
//   csr (APB)  in         psel/penable   six configuration registers
//
// A request is registered on acceptance and its result is then registered in
// the result register; one request is taken per cycle unless the result stalls.
// The state update happens as the request moves into the result register.
// A stalled result holds the request register, which then backs up req_chan.
// Synchronous active-high reset restores the state and register defaults.
// ----------------------------------------------------------------------------
module feeder_jam_recovery_fsm (
   input  logic                           clock,
   input  logic                           reset,
   fjr_req_if.sink                        req_chan,
   fjr_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fjr_pkg::ADDR_W-1:0]     paddr,
   input  logic [fjr_pkg::DATA_W-1:0]     pwdata,
   output logic [fjr_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);
   import fjr_pkg::*;

   cfg_type                   cfg_ff;
   ctx_type                   ctx_ff;
   ctx_type                   ctx_in;
   rsp_type                   rsp_in;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;
   logic                      in_valid_ff;
   logic signed [TORQUE_W-1:0] in_torque_ff;
   logic signed [ANGLE_W-1:0] in_angle_ff;
   logic [MS_W-1:0]           in_now_ff;
   logic                      advance;
   logic                      take;
   logic [2:0]                reg_index;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign reg_index      = paddr[ADDR_W-1:2];
   assign pready         = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.torque_threshold <= RST_TORQUE_THRESHOLD;
         cfg_ff.suspect_ticks    <= RST_SUSPECT_TICKS;
         cfg_ff.recover_ticks    <= RST_RECOVER_TICKS;
         cfg_ff.stall_ticks      <= RST_STALL_TICKS;
         cfg_ff.hold_ms          <= RST_HOLD_MS;
         cfg_ff.backoff_angle    <= RST_BACKOFF_ANGLE;
      end else if (psel && penable && pwrite) begin
         unique case (reg_index)
            REG_TORQUE_THRESHOLD: cfg_ff.torque_threshold <= pwdata[THR_W-1:0];
            REG_SUSPECT_TICKS:    cfg_ff.suspect_ticks    <= pwdata[TICK_W-1:0];
            REG_RECOVER_TICKS:    cfg_ff.recover_ticks    <= pwdata[TICK_W-1:0];
            REG_STALL_TICKS:      cfg_ff.stall_ticks      <= pwdata[TICK_W-1:0];
            REG_HOLD_MS:          cfg_ff.hold_ms          <= pwdata[HOLD_W-1:0];
            REG_BACKOFF_ANGLE:    cfg_ff.backoff_angle    <= pwdata[BACKOFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_TORQUE_THRESHOLD: prdata = DATA_W'(cfg_ff.torque_threshold);
         REG_SUSPECT_TICKS:    prdata = DATA_W'(cfg_ff.suspect_ticks);
         REG_RECOVER_TICKS:    prdata = DATA_W'(cfg_ff.recover_ticks);
         REG_STALL_TICKS:      prdata = DATA_W'(cfg_ff.stall_ticks);
         REG_HOLD_MS:          prdata = DATA_W'(cfg_ff.hold_ms);
         REG_BACKOFF_ANGLE:    prdata = DATA_W'(cfg_ff.backoff_angle);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_torque_ff <= req_chan.torque;
         in_angle_ff  <= req_chan.angle;
         in_now_ff    <= req_chan.now_ms;
      end
   end

   fjr_step u_step (
      .cfg      (cfg_ff),
      .ctx      (ctx_ff),
      .torque   (in_torque_ff),
      .angle    (in_angle_ff),
      .now_ms   (in_now_ff),
      .ctx_next (ctx_in),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            ctx_ff <= ctx_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.jam_state        = rsp_ff.jam_state;
   assign rsp_chan.run_normal_drive = rsp_ff.run_normal_drive;
   assign rsp_chan.mode_command     = rsp_ff.mode_command;
   assign rsp_chan.target_command   = rsp_ff.target_command;
   assign rsp_chan.angle_update     = rsp_ff.angle_update;
   assign rsp_chan.target_angle     = rsp_ff.target_angle;
   assign rsp_chan.clear_drive      = rsp_ff.clear_drive;

   a_run_only_backoff : assert property (@(posedge clock) disable iff (reset)
      (ctx_ff.low_torque_run != '0 || ctx_ff.high_torque_run != '0)
         |-> ctx_ff.jam_state == ST_BACKOFF)
      else $error("torque run counter set outside backing off");

   a_runs_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(ctx_ff.low_torque_run != '0 && ctx_ff.high_torque_run != '0))
      else $error("low and high torque runs both counting");

   a_react_fresh : assert property (@(posedge clock) disable iff (reset)
      ctx_ff.jam_state == ST_REACT |-> ctx_ff.ticks_in_state == '0)
      else $error("react state held for more than one tick");

   a_angle_cmd : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.mode_command == MODE_ANGLE
         |-> rsp_ff.target_command && rsp_ff.jam_state == ST_BACKOFF)
      else $error("angle command without entering backing off");

   a_state_step : assert property (@(posedge clock) disable iff (reset)
      advance |=> ctx_ff.jam_state == rsp_ff.jam_state)
      else $error("reported state differs from stored state");

endmodule

// ----- rtl/fjr_step.sv -----
// ----------------------------------------------------------------------------
// fjr_step
// Next-state and result logic for one control tick of the jam handler.
// ----------------------------------------------------------------------------
module fjr_step (
   input  fjr_pkg::cfg_type                    cfg,
   input  fjr_pkg::ctx_type                    ctx,
   input  logic signed [fjr_pkg::TORQUE_W-1:0] torque,
   input  logic signed [fjr_pkg::ANGLE_W-1:0]  angle,
   input  logic [fjr_pkg::MS_W-1:0]            now_ms,
   output fjr_pkg::ctx_type                    ctx_next,
   output fjr_pkg::rsp_type                    rsp
);
   import fjr_pkg::*;

   logic [TORQUE_W:0]    mag;
   logic                 high;
   logic [TICK_W-1:0]    tick_inc;
   logic [TICK_W-1:0]    low_inc;
   logic [TICK_W-1:0]    high_inc;
   logic signed [ANGLE_W:0] diff;
   logic [ANGLE_W-1:0]   backoff_target;
   logic [MS_W-1:0]      start_eff;
   logic [MS_W-1:0]      elapsed;

   always_comb begin
      if (torque[TORQUE_W-1]) begin
         mag = -{torque[TORQUE_W-1], torque};
      end else begin
         mag = {1'b0, torque};
      end
      high = mag >= {2'b00, cfg.torque_threshold};

      tick_inc = (ctx.ticks_in_state == '1) ? ctx.ticks_in_state
                                            : ctx.ticks_in_state + TICK_W'(1);
      low_inc  = (ctx.low_torque_run == '1) ? ctx.low_torque_run
                                            : ctx.low_torque_run + TICK_W'(1);
      high_inc = (ctx.high_torque_run == '1) ? ctx.high_torque_run
                                             : ctx.high_torque_run + TICK_W'(1);

      diff = {angle[ANGLE_W-1], angle} - {{(ANGLE_W+1-BACKOFF_W){1'b0}}, cfg.backoff_angle};
      if (diff[ANGLE_W] != diff[ANGLE_W-1]) begin
         backoff_target = {1'b1, {(ANGLE_W-1){1'b0}}};
      end else begin
         backoff_target = diff[ANGLE_W-1:0];
      end

      start_eff = (tick_inc == TICK_W'(1)) ? now_ms : ctx.stall_start_ms;
      elapsed   = now_ms - start_eff;

      ctx_next = ctx;
      ctx_next.ticks_in_state = tick_inc;
      rsp = '0;

      unique case (ctx.jam_state)
         ST_NORMAL: begin
            rsp.run_normal_drive = 1'b1;
            if (high) begin
               ctx_next.jam_state      = ST_SUSPECT;
               ctx_next.ticks_in_state = '0;
            end
         end
         ST_SUSPECT: begin
            rsp.run_normal_drive = 1'b1;
            if (tick_inc >= cfg.suspect_ticks) begin
               ctx_next.jam_state      = ST_REACT;
               ctx_next.ticks_in_state = '0;
            end else if (!high) begin
               ctx_next.jam_state      = ST_NORMAL;
               ctx_next.ticks_in_state = '0;
            end
         end
         ST_REACT: begin
            rsp.mode_command        = MODE_ANGLE;
            rsp.target_command      = 1'b1;
            rsp.angle_update        = 1'b1;
            rsp.target_angle        = backoff_target;
            ctx_next.jam_state      = ST_BACKOFF;
            ctx_next.ticks_in_state = '0;
         end
         ST_BACKOFF: begin
            if (!high) begin
               ctx_next.high_torque_run = '0;
               ctx_next.low_torque_run  = low_inc;
               if (low_inc >= cfg.recover_ticks) begin
                  ctx_next.low_torque_run = '0;
                  ctx_next.jam_state      = ST_NORMAL;
                  ctx_next.ticks_in_state = '0;
               end
            end else begin
               ctx_next.low_torque_run  = '0;
               ctx_next.high_torque_run = high_inc;
               if (high_inc >= cfg.stall_ticks) begin
                  ctx_next.high_torque_run = '0;
                  ctx_next.jam_state       = ST_STALLED;
                  ctx_next.ticks_in_state  = '0;
               end
            end
         end
         ST_STALLED: begin
            rsp.run_normal_drive    = 1'b1;
            rsp.mode_command        = MODE_OPEN;
            rsp.clear_drive         = 1'b1;
            rsp.angle_update        = 1'b1;
            rsp.target_angle        = angle;
            ctx_next.stall_start_ms = start_eff;
            if (elapsed > {{(MS_W-HOLD_W){1'b0}}, cfg.hold_ms}) begin
               ctx_next.stall_start_ms = now_ms;
               ctx_next.jam_state      = ST_NORMAL;
               ctx_next.ticks_in_state = '0;
            end
         end
         default: begin
            ctx_next.jam_state      = ST_NORMAL;
            ctx_next.ticks_in_state = '0;
         end
      endcase

      rsp.jam_state = ctx_next.jam_state;
   end

endmodule
